### rtl/sml_pkg.sv
// Shared constants, types and helpers for the struct member layout block.
`timescale 1ns / 1ps

package sml_pkg;

    // Width of all running sizes and offsets
    localparam int SIZE_BITS   = 24;
    localparam int CNT_W       = $clog2(SIZE_BITS + 1);
    localparam int PACK_W      = 9;
    localparam int FBITS_W     = 7;
    localparam int BITPOS_W    = 3;
    // Stream payloads rounded up to whole bytes
    localparam int S_TDATA_W   = ((SIZE_BITS + FBITS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * SIZE_BITS + BITPOS_W + 1 + 7) / 8) * 8;

    // Request into the serial remainder unit
    typedef struct packed {
        logic                 start;
        logic [SIZE_BITS-1:0] dividend;
        logic [SIZE_BITS-1:0] divisor;
    } sml_rem_req_t;

    // Status back from the serial remainder unit
    typedef struct packed {
        logic                 done;
        logic [SIZE_BITS-1:0] remainder;
    } sml_rem_sts_t;

    // Clamp a one-bit-wider sum to the largest size
    function automatic logic [SIZE_BITS-1:0] sml_sat(input logic [SIZE_BITS:0] sum);
        logic [SIZE_BITS-1:0] res;
        res = sum[SIZE_BITS] ? {SIZE_BITS{1'b1}} : sum[SIZE_BITS-1:0];
        return res;
    endfunction

endpackage

### rtl/struct_member_offset_layout.sv
// Top level: member layout sequencer around a shared serial remainder unit.
//
//  Channel   Handshake                Payload
//  s_        s_tvalid / s_tready      s_tdata (size, bits), s_tuser (flex array),
//                                     s_tlast (last member)
//  m_        m_tvalid / m_tready      m_tdata (offset, bit, size, overflow), m_tlast (final)
//  cfg_      cfg_we                   cfg_wdata (pack alignment)
//
// A bit-field member passes through the step and last-member states to the done state;
// an ordinary member also passes through the member state, and through a remainder pass
// (a load plus 24 steps) when it needs alignment. A last member with pack above 1 adds
// another remainder pass for the total. The remainder unit is the only arithmetic loop.
// Reset (aresetn low, synchronous) clears the running size, pack and handshakes.
// s_tready is high only while idle; idle begins in the same cycle as the result is
// presented; a finished result waits in the output register for m_tready, and the next
// member may be accepted meanwhile.
`timescale 1ns / 1ps

module struct_member_offset_layout
    import sml_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config
    input  logic                 cfg_we,
    input  logic [PACK_W-1:0]    cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // member_size[23:0], field_bits[30:24], zero pad
    input  logic                 s_tuser,   // flex_array
    input  logic                 s_tlast,   // last_member
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // byte_offset[23:0], bit_position[26:24],
                                            // struct_size[50:27], size_overflow[51], zero pad
    output logic                 m_tlast    // is_final
);

    typedef enum logic [6:0] {
        ST_IDLE       = 7'b0000001,
        ST_STEP       = 7'b0000010,
        ST_ALIGN_WAIT = 7'b0000100,
        ST_MEMBER     = 7'b0001000,
        ST_LAST       = 7'b0010000,
        ST_TOTAL_WAIT = 7'b0100000,
        ST_DONE       = 7'b1000000
    } state_t;

    state_t               state_reg,  state_next;
    logic [PACK_W-1:0]    pack_reg,   pack_next;
    logic [SIZE_BITS-1:0] bytes_reg,  bytes_next;
    logic [BITPOS_W-1:0]  bits_reg,   bits_next;
    logic                 ovf_reg,    ovf_next;
    logic [SIZE_BITS-1:0] size_reg,   size_next;
    logic [FBITS_W-1:0]   fbits_reg,  fbits_next;
    logic                 flex_reg,   flex_next;
    logic                 last_reg,   last_next;
    logic [SIZE_BITS-1:0] align_reg,  align_next;
    logic [SIZE_BITS-1:0] off_reg,    off_next;
    logic [BITPOS_W-1:0]  bitpos_reg, bitpos_next;
    logic [SIZE_BITS-1:0] total_reg,  total_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    logic [SIZE_BITS-1:0] pack_ext;
    logic [SIZE_BITS-1:0] align_c;
    logic [SIZE_BITS:0]   inc_sum;
    logic [SIZE_BITS-1:0] bytes_closed;
    logic                 close_ovf;
    logic [FBITS_W:0]     bit_sum;
    logic [SIZE_BITS:0]   bf_sum;
    logic [SIZE_BITS:0]   align_sum;
    logic [SIZE_BITS:0]   size_sum;
    logic [SIZE_BITS:0]   total_sum;
    logic                 out_free;
    sml_rem_req_t         rem_req;
    sml_rem_sts_t         rem_sts;

    sml_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .sts     (rem_sts)
    );

    // Shared helper terms
    assign pack_ext     = SIZE_BITS'(pack_reg);
    assign align_c      = (pack_reg != '0 && size_reg > pack_ext) ? pack_ext : size_reg;
    assign inc_sum      = {1'b0, bytes_reg} + (SIZE_BITS + 1)'(1);
    assign close_ovf    = (bits_reg != '0) && inc_sum[SIZE_BITS];
    assign bytes_closed = (bits_reg != '0) ? sml_sat(inc_sum) : bytes_reg;
    assign bit_sum      = {1'b0, fbits_reg} + (FBITS_W + 1)'(bits_reg);
    assign bf_sum       = {1'b0, bytes_reg} + (SIZE_BITS + 1)'(bit_sum[FBITS_W:3]);
    assign align_sum    = {1'b0, bytes_reg} + {1'b0, align_reg - rem_sts.remainder};
    assign size_sum     = {1'b0, bytes_reg} + {1'b0, size_reg};
    assign total_sum    = {1'b0, total_reg} + {1'b0, pack_ext - rem_sts.remainder};
    assign out_free     = !m_valid_reg || m_tready;

    // Remainder requests: member alignment from the step state, total rounding
    // from the last-member state
    always_comb begin
        rem_req.start    = 1'b0;
        rem_req.dividend = bytes_closed;
        rem_req.divisor  = align_c;
        if (state_reg == ST_STEP) begin
            rem_req.start = (fbits_reg == '0) && (align_c > SIZE_BITS'(1));
        end else if (state_reg == ST_LAST) begin
            rem_req.dividend = bytes_closed;
            rem_req.divisor  = pack_ext;
            rem_req.start    = last_reg && (pack_reg > PACK_W'(1));
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        pack_next    = cfg_we ? cfg_wdata : pack_reg;
        bytes_next   = bytes_reg;
        bits_next    = bits_reg;
        ovf_next     = ovf_reg;
        size_next    = size_reg;
        fbits_next   = fbits_reg;
        flex_next    = flex_reg;
        last_next    = last_reg;
        align_next   = align_reg;
        off_next     = off_reg;
        bitpos_next  = bitpos_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    size_next  = s_tdata[SIZE_BITS-1:0];
                    fbits_next = s_tdata[SIZE_BITS +: FBITS_W];
                    flex_next  = s_tuser;
                    last_next  = s_tlast;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (fbits_reg == '0) begin
                    // ordinary member: close partial byte, then align
                    bytes_next = bytes_closed;
                    bits_next  = '0;
                    ovf_next   = ovf_reg || close_ovf;
                    align_next = align_c;
                    state_next = (align_c > SIZE_BITS'(1)) ? ST_ALIGN_WAIT : ST_MEMBER;
                end else begin
                    // bit-field: take current position, advance by its width
                    off_next    = bytes_reg;
                    bitpos_next = bits_reg;
                    bytes_next  = sml_sat(bf_sum);
                    ovf_next    = ovf_reg || bf_sum[SIZE_BITS];
                    bits_next   = bit_sum[2:0];
                    state_next  = ST_LAST;
                end
            end
            ST_ALIGN_WAIT: begin
                if (rem_sts.done) begin
                    if (rem_sts.remainder != '0) begin
                        bytes_next = sml_sat(align_sum);
                        ovf_next   = ovf_reg || align_sum[SIZE_BITS];
                    end
                    state_next = ST_MEMBER;
                end
            end
            ST_MEMBER: begin
                off_next    = bytes_reg;
                bitpos_next = '0;
                if (!flex_reg) begin
                    bytes_next = sml_sat(size_sum);
                    ovf_next   = ovf_reg || size_sum[SIZE_BITS];
                end
                state_next = ST_LAST;
            end
            ST_LAST: begin
                if (!last_reg) begin
                    total_next = '0;
                    state_next = ST_DONE;
                end else begin
                    total_next = bytes_closed;
                    ovf_next   = ovf_reg || close_ovf;
                    state_next = (pack_reg > PACK_W'(1)) ? ST_TOTAL_WAIT : ST_DONE;
                end
            end
            ST_TOTAL_WAIT: begin
                if (rem_sts.done) begin
                    if (rem_sts.remainder != '0) begin
                        total_next = sml_sat(total_sum);
                        ovf_next   = ovf_reg || total_sum[SIZE_BITS];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({ovf_reg, total_reg, bitpos_reg, off_reg});
                    m_last_next  = last_reg;
                    if (last_reg) begin
                        bytes_next = '0;
                        bits_next  = '0;
                        ovf_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pack_reg    <= '0;
            bytes_reg   <= '0;
            bits_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pack_reg    <= pack_next;
            bytes_reg   <= bytes_next;
            bits_reg    <= bits_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        fbits_reg  <= fbits_next;
        flex_reg   <= flex_next;
        last_reg   <= last_next;
        align_reg  <= align_next;
        off_reg    <= off_next;
        bitpos_reg <= bitpos_next;
        total_reg  <= total_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### rtl/sml_rem.sv
// Serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module sml_rem
    import sml_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  sml_rem_req_t req,
    output sml_rem_sts_t sts
);

    logic [SIZE_BITS-1:0] rem_reg,  rem_next;
    logic [SIZE_BITS-1:0] dvd_reg,  dvd_next;
    logic [SIZE_BITS-1:0] dvs_reg,  dvs_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SIZE_BITS:0]   trial;
    logic [SIZE_BITS:0]   diff;

    // One shift-compare-subtract step
    assign trial = {rem_reg, dvd_reg[SIZE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(SIZE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[SIZE_BITS-1:0]
                                                  : trial[SIZE_BITS-1:0];
            dvd_next = {dvd_reg[SIZE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg;

endmodule
